[src/fsf_pkg.sv]
// shared constants, codes and word types of the flagged substring finder
`timescale 1ns / 1ps

package fsf_pkg;

    localparam int MAX_PATTERN   = 16;
    localparam int POSITION_BITS = 16;

    localparam int PAT_IDX_W     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PLEN_W        = $clog2(MAX_PATTERN + 1);
    localparam int PAT_REG_BYTES = 16;
    localparam int PLEN_REG_W    = 5;
    localparam int START_W       = 16;
    localparam int OUT_POS_W     = 16;

    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCOUNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_POSITION = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CASE_FOLD      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SLASH_FOLD     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FIND_LAST      = 3'd6;

    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CASE_BIT     = 8'h20;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_END,
        OP_BYTE_END
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic  push;
        item_t item;
    } q_wr_t;

    typedef struct packed {
        logic  avail;
        item_t item;
    } q_rd_t;

endpackage

[src/fsf_front.sv]
// front end: takes input words, classifies them and drops empty ones
`timescale 1ns / 1ps

module fsf_front (
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         text_byte,
    input  logic               byte_valid,
    input  logic               end_of_text,
    input  logic               q_full,
    output fsf_pkg::q_wr_t     q_wr
);

    always_comb
    begin
        in_ready       = !q_full;
        // a word with neither a byte nor an end mark is taken and dropped
        q_wr.push      = in_valid && !q_full && (byte_valid || end_of_text);
        q_wr.item.data = text_byte;
        if (byte_valid && end_of_text)
        begin
            q_wr.item.op = fsf_pkg::OP_BYTE_END;
        end
        else if (end_of_text)
        begin
            q_wr.item.op = fsf_pkg::OP_END;
        end
        else
        begin
            q_wr.item.op = fsf_pkg::OP_BYTE;
        end
    end

endmodule

[src/fsf_queue.sv]
// short fifo of classified words between front and back end
`timescale 1ns / 1ps

module fsf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  fsf_pkg::q_wr_t wr,
    output logic           full,
    input  logic           pop,
    output fsf_pkg::q_rd_t rd
);

    fsf_pkg::item_t                       entry_reg [fsf_pkg::QUEUE_DEPTH];
    logic [fsf_pkg::QPTR_W-1:0]           wptr_reg;
    logic [fsf_pkg::QPTR_W-1:0]           wptr_next;
    logic [fsf_pkg::QPTR_W-1:0]           rptr_reg;
    logic [fsf_pkg::QPTR_W-1:0]           rptr_next;
    logic [fsf_pkg::QCOUNT_W-1:0]         count_reg;
    logic [fsf_pkg::QCOUNT_W-1:0]         count_next;

    localparam logic [fsf_pkg::QPTR_W-1:0] PTR_LAST = fsf_pkg::QPTR_W'(fsf_pkg::QUEUE_DEPTH - 1);
    localparam logic [fsf_pkg::QCOUNT_W-1:0] COUNT_FULL =
        fsf_pkg::QCOUNT_W'(fsf_pkg::QUEUE_DEPTH);

    always_comb
    begin
        full     = (count_reg == COUNT_FULL);
        rd.avail = (count_reg != '0);
        rd.item  = entry_reg[rptr_reg];

        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (wr.push)
        begin
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
        end
        if (wr.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !wr.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            entry_reg[wptr_reg] <= wr.item;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        wr.push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("queue count out of range");

endmodule

[src/fsf_back.sv]
// back end: config registers, match window, position tracking and result register
`timescale 1ns / 1ps

module fsf_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [fsf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fsf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  fsf_pkg::q_rd_t                      rd,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                found,
    output logic [fsf_pkg::OUT_POS_W-1:0]       match_position,
    output logic [fsf_pkg::OUT_POS_W-1:0]       text_length,
    output logic                                length_overflow
);

    localparam int PB = fsf_pkg::POSITION_BITS;

    // configuration
    logic [63:0]                          pattern_low_reg;
    logic [63:0]                          pattern_high_reg;
    logic [fsf_pkg::PLEN_REG_W-1:0]       pattern_length_reg;
    logic [fsf_pkg::START_W-1:0]          start_position_reg;
    logic                                 case_fold_reg;
    logic                                 slash_fold_reg;
    logic                                 find_last_reg;

    // stream state
    logic [7:0]                           window_reg [fsf_pkg::MAX_PATTERN];
    logic [7:0]                           window_next [fsf_pkg::MAX_PATTERN];
    logic [PB-1:0]                        byte_count_reg;
    logic [PB-1:0]                        byte_count_next;
    logic                                 hit_seen_reg;
    logic                                 hit_seen_next;
    logic [PB-1:0]                        hit_index_reg;
    logic [PB-1:0]                        hit_index_next;
    logic                                 count_overflow_reg;
    logic                                 count_overflow_next;

    // result register
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic                                 found_reg;
    logic [fsf_pkg::OUT_POS_W-1:0]        match_position_reg;
    logic [fsf_pkg::OUT_POS_W-1:0]        text_length_reg;
    logic                                 length_overflow_reg;

    // datapath
    logic [7:0]                           shifted [fsf_pkg::MAX_PATTERN];
    logic [7:0]                           pat_byte [fsf_pkg::MAX_PATTERN];
    logic [8*fsf_pkg::PAT_REG_BYTES-1:0]  pattern_all;
    logic [fsf_pkg::PLEN_W-1:0]           plen;
    logic [fsf_pkg::PAT_IDX_W-1:0]        widx;
    logic                                 match_all;
    logic                                 has_byte;
    logic                                 has_end;
    logic                                 take;
    logic                                 is_end;
    logic                                 sat;
    logic [PB:0]                          count_p1;
    logic [PB-1:0]                        cand;
    logic                                 hit;
    logic                                 record;
    logic                                 s_hit_seen;
    logic [PB-1:0]                        s_hit_index;
    logic [PB-1:0]                        s_count;
    logic                                 s_overflow;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= fsf_pkg::CH_UPPER_A && c <= fsf_pkg::CH_UPPER_Z) ?
               (c ^ fsf_pkg::CASE_BIT) : c;
    endfunction

    function automatic logic [7:0] fold_slash(input logic [7:0] c);
        return (c == fsf_pkg::CH_BACKSLASH) ? fsf_pkg::CH_SLASH : c;
    endfunction

    function automatic logic bytes_match(input logic [7:0] t, input logic [7:0] p,
                                         input logic cf, input logic sf);
        return (t == p) || (cf && (fold_case(t) == fold_case(p))) ||
               (sf && (fold_slash(t) == fold_slash(p)));
    endfunction

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            start_position_reg <= '0;
            case_fold_reg      <= 1'b0;
            slash_fold_reg     <= 1'b0;
            find_last_reg      <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                fsf_pkg::REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data[63:0];
                fsf_pkg::REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data[63:0];
                fsf_pkg::REG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[fsf_pkg::PLEN_REG_W-1:0];
                fsf_pkg::REG_START_POSITION:
                    start_position_reg <= cfg_data[fsf_pkg::START_W-1:0];
                fsf_pkg::REG_CASE_FOLD:      case_fold_reg      <= cfg_data[0];
                fsf_pkg::REG_SLASH_FOLD:     slash_fold_reg     <= cfg_data[0];
                fsf_pkg::REG_FIND_LAST:      find_last_reg      <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        has_byte = (rd.item.op == fsf_pkg::OP_BYTE) || (rd.item.op == fsf_pkg::OP_BYTE_END);
        has_end  = (rd.item.op == fsf_pkg::OP_END) || (rd.item.op == fsf_pkg::OP_BYTE_END);
        // an end word waits until the result register is free
        pop      = rd.avail && (!has_end || !out_valid_reg || out_ready);
        take     = pop && has_byte;
        is_end   = pop && has_end;

        if (int'(pattern_length_reg) > fsf_pkg::MAX_PATTERN)
        begin
            plen = fsf_pkg::PLEN_W'(fsf_pkg::MAX_PATTERN);
        end
        else
        begin
            plen = fsf_pkg::PLEN_W'(pattern_length_reg);
        end

        pattern_all = {pattern_high_reg, pattern_low_reg};
        for (int j = 0; j < fsf_pkg::MAX_PATTERN; j++)
        begin
            if (j < fsf_pkg::PAT_REG_BYTES)
            begin
                pat_byte[j] = pattern_all[8*(j % fsf_pkg::PAT_REG_BYTES) +: 8];
            end
            else
            begin
                pat_byte[j] = '0;
            end
        end

        // window as it stands with the new byte, newest at index 0
        shifted[0] = rd.item.data;
        for (int k = 1; k < fsf_pkg::MAX_PATTERN; k++)
        begin
            shifted[k] = window_reg[k-1];
        end

        match_all = 1'b1;
        widx      = '0;
        for (int j = 0; j < fsf_pkg::MAX_PATTERN; j++)
        begin
            if (j < int'(plen))
            begin
                widx = fsf_pkg::PAT_IDX_W'(int'(plen) - 1 - j);
                if (!bytes_match(shifted[widx], pat_byte[j], case_fold_reg, slash_fold_reg))
                begin
                    match_all = 1'b0;
                end
            end
        end

        sat      = (byte_count_reg == fsf_pkg::POS_MAX);
        count_p1 = {1'b0, byte_count_reg} + 1'b1;
        if (plen == '0)
        begin
            // empty pattern matches at the index of the incoming byte
            cand = byte_count_reg;
            hit  = 1'b1;
        end
        else
        begin
            cand = PB'(count_p1 - (PB+1)'(plen));
            hit  = (count_p1 >= (PB+1)'(plen)) && match_all;
        end
        record = take && !sat && hit && ({1'b0, cand} >= (PB+1)'(start_position_reg));

        s_count     = byte_count_reg;
        s_overflow  = count_overflow_reg;
        s_hit_seen  = hit_seen_reg;
        s_hit_index = hit_index_reg;
        for (int k = 0; k < fsf_pkg::MAX_PATTERN; k++)
        begin
            window_next[k] = window_reg[k];
        end
        if (take)
        begin
            if (sat)
            begin
                s_overflow = 1'b1;
            end
            else
            begin
                for (int k = 0; k < fsf_pkg::MAX_PATTERN; k++)
                begin
                    window_next[k] = shifted[k];
                end
                s_count = count_p1[PB-1:0];
                if (record)
                begin
                    if (!hit_seen_reg || find_last_reg)
                    begin
                        s_hit_index = cand;
                    end
                    s_hit_seen = 1'b1;
                end
            end
        end

        if (is_end)
        begin
            byte_count_next     = '0;
            count_overflow_next = 1'b0;
            hit_seen_next       = 1'b0;
            hit_index_next      = '0;
        end
        else
        begin
            byte_count_next     = s_count;
            count_overflow_next = s_overflow;
            hit_seen_next       = s_hit_seen;
            hit_index_next      = s_hit_index;
        end

        if (is_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg     <= '0;
            count_overflow_reg <= 1'b0;
            hit_seen_reg       <= 1'b0;
            hit_index_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            byte_count_reg     <= byte_count_next;
            count_overflow_reg <= count_overflow_next;
            hit_seen_reg       <= hit_seen_next;
            hit_index_reg      <= hit_index_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < fsf_pkg::MAX_PATTERN; k++)
        begin
            window_reg[k] <= window_next[k];
        end
        if (is_end)
        begin
            found_reg           <= s_hit_seen;
            match_position_reg  <= s_hit_seen ? fsf_pkg::OUT_POS_W'(s_hit_index) :
                                                fsf_pkg::OUT_POS_W'(s_count);
            text_length_reg     <= fsf_pkg::OUT_POS_W'(s_count);
            length_overflow_reg <= s_overflow;
        end
    end

    assign out_valid       = out_valid_reg;
    assign found           = found_reg;
    assign match_position  = match_position_reg;
    assign text_length     = text_length_reg;
    assign length_overflow = length_overflow_reg;

    a_found_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (match_position_reg <= text_length_reg))
        else $error("match start beyond text length");

    a_miss_gives_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (match_position_reg == text_length_reg))
        else $error("miss must report text length");

    a_overflow_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        count_overflow_reg |-> (byte_count_reg == fsf_pkg::POS_MAX))
        else $error("overflow flag without saturated count");

    a_end_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (is_end && out_valid_reg) |-> out_ready)
        else $error("result overwritten before it was taken");

endmodule

[src/flagged_substring_finder_core.sv]
// top level of the flagged substring finder
`timescale 1ns / 1ps

// Streams the bytes of one text string and searches it for a configured pattern of up
// to 16 bytes, with optional ASCII case folding and backslash-to-slash folding, counting
// only match starts at or after start_position. A word with end_of_text set yields one
// result: the first (or, with find_last, the last) match start, or the text length when
// nothing matched, plus the saturating length and its overflow flag. Words carrying
// neither a valid byte nor an end mark are taken and dropped. The block sustains one
// word per clock while the queue is not full: a 4-entry queue decouples the input
// side from the match stage, which shifts the window and compares all pattern bytes
// in parallel; each end word's result is held in an output register, so a stalled
// result only holds back a later end word. Registers must be written only while the
// block is idle; the block itself does not enforce this.
module flagged_substring_finder_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [fsf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fsf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          text_byte,
    input  logic                                byte_valid,
    input  logic                                end_of_text,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                found,
    output logic [fsf_pkg::OUT_POS_W-1:0]       match_position,
    output logic [fsf_pkg::OUT_POS_W-1:0]       text_length,
    output logic                                length_overflow
);

    fsf_pkg::q_wr_t q_wr;
    fsf_pkg::q_rd_t q_rd;
    logic           q_full;
    logic           q_pop;

    fsf_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .byte_valid  (byte_valid),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .q_wr        (q_wr)
    );

    fsf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .full  (q_full),
        .pop   (q_pop),
        .rd    (q_rd)
    );

    fsf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rd              (q_rd),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .found           (found),
        .match_position  (match_position),
        .text_length     (text_length),
        .length_overflow (length_overflow)
    );

endmodule
